@@ rtl/core/aespks_pkg.sv @@
package aespks_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] RegKeyLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMask     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCipherLo = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCipherHi = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPlainLo  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPlainHi  = 3'd6;

  // bytes of a 128-bit block, byte 0 in bits 7:0
  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   found;
    block_t key;
  } result_t;

  localparam logic [7:0] RconTab [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SboxTab[x];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ rtl/core/aespks_stream_if.sv @@
interface aespks_stream_if #(
  parameter int unsigned Width = 64
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, input ready, output data);
  modport sink   (input valid, output ready, input data);
endinterface

@@ rtl/core/aespks_key_build.sv @@
// merges index bytes into the masked key positions, registered
module aespks_key_build #(
  parameter int unsigned MaxGuessed = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  aespks_pkg::block_t  known_key_i,
  input  logic [15:0]         mask_i,
  input  logic [63:0]         index_i,
  output aespks_pkg::block_t  key_o
);
  import aespks_pkg::*;

  localparam int unsigned CntW = 5;

  block_t key_d;
  block_t key_q;

  // each masked byte takes the next index byte while any remain
  always_comb begin
    logic [CntW-1:0] used;
    used  = '0;
    key_d = known_key_i;
    for (int i = 0; i < 16; i++) begin
      if (mask_i[i]) begin
        if (used < CntW'(MaxGuessed)) begin
          key_d[8*i +: 8] = index_i[8*used[2:0] +: 8];
        end else begin
          key_d[8*i +: 8] = 8'h00;
        end
        used = used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;
endmodule

@@ rtl/core/aespks_round_cell.sv @@
// one aes round plus its key expansion step; passes key and state onward
module aespks_round_cell #(
  parameter logic [7:0] Rcon      = 8'h01,
  parameter bit         LastRound = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  aespks_pkg::block_t state_i,
  input  aespks_pkg::block_t rkey_i,
  input  aespks_pkg::block_t tkey_i,
  output aespks_pkg::block_t state_o,
  output aespks_pkg::block_t rkey_o,
  output aespks_pkg::block_t tkey_o
);
  import aespks_pkg::*;

  block_t rk_d, st_d, sub, mix;
  block_t rk_q, st_q, tk_q;

  // next round key
  always_comb begin
    logic [31:0] w;
    w = {sbox(rkey_i[103:96]), sbox(rkey_i[127:120]),
         sbox(rkey_i[119:112]), sbox(rkey_i[111:104]) ^ Rcon};
    rk_d[31:0]   = rkey_i[31:0] ^ w;
    rk_d[63:32]  = rkey_i[63:32] ^ rk_d[31:0];
    rk_d[95:64]  = rkey_i[95:64] ^ rk_d[63:32];
    rk_d[127:96] = rkey_i[127:96] ^ rk_d[95:64];
  end

  // sub bytes with shift rows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sub[8*(i+4*c) +: 8] = sbox(state_i[8*(i+4*((c+i)%4)) +: 8]);
      end
    end
  end

  // mix columns
  always_comb begin
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      a0 = sub[32*c +: 8];
      a1 = sub[32*c+8 +: 8];
      a2 = sub[32*c+16 +: 8];
      a3 = sub[32*c+24 +: 8];
      x  = a0 ^ a1 ^ a2 ^ a3;
      mix[32*c +: 8]    = a0 ^ x ^ gf_double(a0 ^ a1);
      mix[32*c+8 +: 8]  = a1 ^ x ^ gf_double(a1 ^ a2);
      mix[32*c+16 +: 8] = a2 ^ x ^ gf_double(a2 ^ a3);
      mix[32*c+24 +: 8] = a3 ^ x ^ gf_double(a3 ^ a0);
    end
  end

  assign st_d = (LastRound ? sub : mix) ^ rk_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rk_q <= rk_d;
      st_q <= st_d;
      tk_q <= tkey_i;
    end
  end

  assign state_o = st_q;
  assign rkey_o  = rk_q;
  assign tkey_o  = tk_q;
endmodule

@@ rtl/core/aes128_partial_key_search_unit.sv @@
// Tests one candidate key per clock. Each accepted index is merged into the
// known key under the missing-byte mask, then runs through a row of ten
// registered aes round cells, one per round with its own key expansion step;
// the final compare against the ciphertext is registered as the result item.
// One item is taken every cycle while the output is not stalled. The whole row
// advances together, so a stalled output halts every stage. The user must
// write configuration only while no items are in flight; the block itself
// does not enforce this.
module aes128_partial_key_search_unit #(
  parameter int unsigned MAX_GUESSED_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [aespks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aespks_pkg::CfgDataW-1:0]  cfg_data_i,
  aespks_stream_if.sink                    in_if,
  aespks_stream_if.source                  out_if
);
  import aespks_pkg::*;

  localparam int unsigned Stages = NumRounds + 2;

  logic [63:0] key_lo_q, key_hi_q, ct_lo_q, ct_hi_q, pt_lo_q, pt_hi_q;
  logic [15:0] mask_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      mask_q   <= '0;
      ct_lo_q  <= '0;
      ct_hi_q  <= '0;
      pt_lo_q  <= '0;
      pt_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyLow:   key_lo_q <= cfg_data_i;
        RegKeyHigh:  key_hi_q <= cfg_data_i;
        RegMask:     mask_q   <= cfg_data_i[15:0];
        RegCipherLo: ct_lo_q  <= cfg_data_i;
        RegCipherHi: ct_hi_q  <= cfg_data_i;
        RegPlainLo:  pt_lo_q  <= cfg_data_i;
        RegPlainHi:  pt_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline valid bits, whole row moves when the output is free
  logic [Stages-1:0] vld_q;
  logic              adv;
  assign adv = !vld_q[Stages-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_if.valid};
    end
  end

  block_t key0;
  aespks_key_build #(.MaxGuessed(MAX_GUESSED_BYTES)) u_key (
    .clk_i, .en_i(adv), .known_key_i({key_hi_q, key_lo_q}), .mask_i(mask_q),
    .index_i(in_if.data), .key_o(key0)
  );

  block_t st [NumRounds+1];
  block_t rk [NumRounds+1];
  block_t tk [NumRounds+1];

  assign st[0] = {pt_hi_q, pt_lo_q} ^ key0;
  assign rk[0] = key0;
  assign tk[0] = key0;

  // row of round cells
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    aespks_round_cell #(.Rcon(RconTab[r]), .LastRound(r == NumRounds - 1)) u_cell (
      .clk_i, .en_i(adv), .state_i(st[r]), .rkey_i(rk[r]), .tkey_i(tk[r]),
      .state_o(st[r+1]), .rkey_o(rk[r+1]), .tkey_o(tk[r+1])
    );
  end

  // compare and output register
  result_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.found <= (st[NumRounds] == {ct_hi_q, ct_lo_q});
      res_q.key   <= tk[NumRounds];
    end
  end

  assign out_if.valid = vld_q[Stages-1];
  assign out_if.data  = {res_q.found, res_q.key};
endmodule
